// ----- sv/line_trace_pid_steering_unit_assert.svh -----
// Assertion macros shared by the steering unit and its window.
// With SYNTHESIS defined every macro expands to nothing.
`ifndef LINE_TRACE_PID_STEERING_UNIT_ASSERT_SVH
`define LINE_TRACE_PID_STEERING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(name, clock, reset, cond) \
  name: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clock, reset, cond)
`define ASSERT_IMPLIES(name, clock, reset, ante, cons)
`define ASSERT_NEXT(name, clock, reset, ante, cons)

`endif

`endif

// ----- sv/ltps_pkg.sv -----
`default_nettype none

package ltps_pkg;

  localparam int DEPTH_DEFAULT = 5;

  localparam int LIGHT_W    = 7;
  localparam int ERR_W      = 8;
  localparam int DIFF_W     = 9;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int POWER_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Quotient of the steering divide; anything at 128 or above saturates.
  localparam int QUO_W     = 7;
  localparam int FACTOR_W  = 7;
  localparam int POW_MAG_W = 8;
  localparam int PROD_W    = POW_MAG_W + FACTOR_W - 1;
  localparam int PQ_W      = 8;
  localparam int STEP_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = CFG_IDX_W'(4);

  localparam logic [LIGHT_W-1:0] CENTER_RESET = LIGHT_W'(50);
  localparam logic [QUO_W-1:0]   STEER_MAX    = QUO_W'(100);
  localparam logic [PROD_W-1:0]  PDIV_TOP     = PROD_W'(100) << (PQ_W - 1);

  localparam logic [STEP_W-1:0] GMUL_LAST = STEP_W'(GAIN_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
  localparam logic [STEP_W-1:0] PMUL_LAST = STEP_W'(FACTOR_W - 1);
  localparam logic [STEP_W-1:0] PDIV_LAST = STEP_W'(PQ_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GMUL,
    ST_NMUL,
    ST_ABS,
    ST_DIV,
    ST_SCALE,
    ST_PMUL,
    ST_PDIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- sv/ltps_window.sv -----
`default_nettype none
`include "line_trace_pid_steering_unit_assert.svh"

module ltps_window
  import ltps_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int SUM_W = ERR_W + $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic signed [ERR_W-1:0] err,
  output logic signed [SUM_W-1:0] sum_upd,
  output logic [CNT_W-1:0]        fill_upd
);

  logic signed [ERR_W-1:0] taps [DEPTH];
  logic [CNT_W-1:0]        fill;
  logic signed [SUM_W-1:0] sum;
  logic                    full;

  assign full = (fill == CNT_W'(DEPTH));

  // Running sum: the oldest error leaves once the window is full.
  assign sum_upd  = sum + SUM_W'(err) - (full ? SUM_W'(taps[DEPTH-1]) : SUM_W'(0));
  assign fill_upd = full ? fill : fill + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
    end else if (push) begin
      fill <= fill_upd;
      sum  <= sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      taps[0] <= err;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  `ASSERT_ALWAYS(fill_in_range, clk, rst, fill <= CNT_W'(DEPTH))
  `ASSERT_IMPLIES(empty_sum_zero, clk, rst, fill == '0, sum == '0)
  `ASSERT_NEXT(push_leaves_entry, clk, rst, push, fill != '0)

endmodule

`default_nettype wire

// ----- sv/line_trace_pid_steering_unit.sv -----
// Channel  Handshake              Word
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in_valid / in_stall    light
// out      out_valid / out_stall  steer, left_power, right_power
//
// Each item runs through the 16-step bit-serial gain multiply, a multiply by
// the held entry count with one step per bit of it (1 to 3 bits at depth 5)
// and the two restoring dividers (7 and 8 steps).
// Reset restores the register defaults and empties the error window.
// A stalled result waits in the output register; the next sample is taken
// meanwhile, and only the final load waits for the register to free up.
`default_nettype none
`include "line_trace_pid_steering_unit_assert.svh"

module line_trace_pid_steering_unit
  import ltps_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [LIGHT_W-1:0]        light,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [POWER_W-1:0] steer,
  output logic signed [POWER_W-1:0] left_power,
  output logic signed [POWER_W-1:0] right_power
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = ERR_W + $clog2(WINDOW_DEPTH);
  localparam int P_W   = GAIN_W + DIFF_W + 1;
  localparam int NUM_W = P_W + CNT_W + 1;
  localparam int A_W   = NUM_W - FRAC_W;
  localparam int REM_W = QUO_W + CNT_W;

  logic [LIGHT_W-1:0]        center_level;
  logic signed [GAIN_W-1:0]  gain_p;
  logic signed [GAIN_W-1:0]  gain_i;
  logic signed [GAIN_W-1:0]  gain_d;
  logic signed [POWER_W-1:0] base_power;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              load_out;

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  last_error;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W-1:0]  sum_upd;
  logic [CNT_W-1:0]         fill_upd;

  logic signed [P_W-1:0]   mp_e;
  logic signed [P_W-1:0]   mp_d;
  logic signed [NUM_W-1:0] mg;
  logic signed [P_W-1:0]   acc_p;
  logic signed [NUM_W-1:0] acc_g;
  logic signed [NUM_W-1:0] pm;
  logic [GAIN_W-1:0]       gp_sh;
  logic [GAIN_W-1:0]       gi_sh;
  logic [GAIN_W-1:0]       gd_sh;
  logic [CNT_W-1:0]        n_sh;
  logic [CNT_W-1:0]        n_items;

  logic                    gain_last;
  logic signed [P_W-1:0]   term_e;
  logic signed [P_W-1:0]   term_d;
  logic signed [NUM_W-1:0] term_g;
  logic signed [P_W-1:0]   acc_p_next;

  logic [NUM_W-1:0] num_abs;
  logic [A_W-1:0]   num_scaled;
  logic             num_sat;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dv;
  logic [QUO_W-1:0] quo;
  logic             neg;
  logic             sat;
  logic [QUO_W-1:0] mag;

  logic signed [POWER_W-1:0] steer_r;
  logic signed [POWER_W-1:0] bp_r;
  logic [POW_MAG_W-1:0]      bp_mag;
  logic [FACTOR_W-1:0]       f_sh;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         bpm;
  logic [PROD_W-1:0]         pdv;
  logic [PQ_W-1:0]           pq;
  logic signed [PQ_W:0]      pq_ext;
  logic signed [PQ_W:0]      scaled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_level <= CENTER_RESET;
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      base_power   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER: center_level <= cfg_data[LIGHT_W-1:0];
        REG_GAIN_P: gain_p       <= cfg_data;
        REG_GAIN_I: gain_i       <= cfg_data;
        REG_GAIN_D: gain_d       <= cfg_data;
        REG_BASE:   base_power   <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  assign err  = $signed({1'b0, light}) - $signed({1'b0, center_level});
  assign diff = DIFF_W'(err) - DIFF_W'(last_error);

  ltps_window #(
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .err      (err),
    .sum_upd  (sum_upd),
    .fill_upd (fill_upd)
  );

  // Two's complement gains: the top bit carries negative weight.
  assign gain_last  = (step == GMUL_LAST);
  assign term_e     = gp_sh[0] ? (gain_last ? -mp_e : mp_e) : '0;
  assign term_d     = gd_sh[0] ? (gain_last ? -mp_d : mp_d) : '0;
  assign term_g     = gi_sh[0] ? (gain_last ? -mg : mg) : '0;
  assign acc_p_next = acc_p + term_e + term_d;

  assign num_abs    = acc_g[NUM_W-1] ? $unsigned(-acc_g) : $unsigned(acc_g);
  assign num_scaled = num_abs[NUM_W-1:FRAC_W];
  assign num_sat    = num_scaled >= (A_W'(n_items) << QUO_W);

  assign mag    = (sat || (quo > STEER_MAX)) ? STEER_MAX : quo;
  assign bp_mag = base_power[POWER_W-1] ? POW_MAG_W'(-base_power) : POW_MAG_W'(base_power);
  assign pq_ext = $signed({1'b0, pq});
  assign scaled = bp_r[POWER_W-1] ? -pq_ext : pq_ext;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_GMUL;
      ST_GMUL:  if (step == GMUL_LAST) state_next = ST_NMUL;
      ST_NMUL:  if ((n_sh >> 1) == '0) state_next = ST_ABS;
      ST_ABS:   state_next = ST_DIV;
      ST_DIV:   if (step == DIV_LAST) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_PMUL;
      ST_PMUL:  if (step == PMUL_LAST) state_next = ST_PDIV;
      ST_PDIV:  if (step == PDIV_LAST) state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    accept   = in_valid && !in_stall;
    load_out = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      last_error <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= '0;
      end else begin
        step <= step + 1'b1;
      end
      if (accept) begin
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mp_e    <= P_W'(err);
          mp_d    <= P_W'(diff);
          mg      <= NUM_W'(sum_upd);
          acc_p   <= '0;
          acc_g   <= '0;
          gp_sh   <= gain_p;
          gi_sh   <= gain_i;
          gd_sh   <= gain_d;
          n_sh    <= fill_upd;
          n_items <= fill_upd;
        end
      end
      ST_GMUL: begin
        acc_p <= acc_p_next;
        acc_g <= acc_g + term_g;
        pm    <= NUM_W'(acc_p_next);
        mp_e  <= mp_e <<< 1;
        mp_d  <= mp_d <<< 1;
        mg    <= mg <<< 1;
        gp_sh <= gp_sh >> 1;
        gi_sh <= gi_sh >> 1;
        gd_sh <= gd_sh >> 1;
      end
      ST_NMUL: begin
        if (n_sh[0]) begin
          acc_g <= acc_g + pm;
        end
        pm   <= pm <<< 1;
        n_sh <= n_sh >> 1;
      end
      ST_ABS: begin
        neg <= acc_g[NUM_W-1];
        sat <= num_sat;
        rem <= num_scaled[REM_W-1:0];
        dv  <= REM_W'(n_items) << (QUO_W - 1);
        quo <= '0;
      end
      ST_DIV: begin
        if (rem >= dv) begin
          rem <= rem - dv;
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dv <= dv >> 1;
      end
      ST_SCALE: begin
        steer_r <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        f_sh    <= STEER_MAX - mag;
        bp_r    <= base_power;
        bpm     <= PROD_W'(bp_mag);
        prod    <= '0;
        pdv     <= PDIV_TOP;
        pq      <= '0;
      end
      ST_PMUL: begin
        if (f_sh[0]) begin
          prod <= prod + bpm;
        end
        bpm  <= bpm << 1;
        f_sh <= f_sh >> 1;
      end
      ST_PDIV: begin
        if (prod >= pdv) begin
          prod <= prod - pdv;
          pq   <= {pq[PQ_W-2:0], 1'b1};
        end else begin
          pq   <= {pq[PQ_W-2:0], 1'b0};
        end
        pdv <= pdv >> 1;
      end
      ST_DONE: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The outer wheel keeps base power; the inner one gets the scaled value.
  always_ff @(posedge clk) begin
    if (load_out) begin
      steer <= steer_r;
      if (steer_r > 8'sd0) begin
        left_power  <= bp_r;
        right_power <= scaled[POWER_W-1:0];
      end else begin
        left_power  <= scaled[POWER_W-1:0];
        right_power <= bp_r;
      end
    end
  end

  `ASSERT_IMPLIES(steer_in_range, clk, rst, out_valid, (steer <= 8'sd100) && (steer >= -8'sd100))
  `ASSERT_IMPLIES(zero_steer_even, clk, rst, out_valid && (steer == '0), left_power == right_power)
  `ASSERT_IMPLIES(load_after_done, clk, rst, $rose(out_valid), $past(state) == ST_DONE)

endmodule

`default_nettype wire

// ----- tb/line_trace_pid_steering_unit_test.sv -----
`timescale 1ns / 100ps

import ltps_pkg::*;

typedef struct packed {
  logic signed [POWER_W-1:0] steer;
  logic signed [POWER_W-1:0] left_power;
  logic signed [POWER_W-1:0] right_power;
} motor_word_t;

// Keeps its own copy of the registers and the error window, works out the
// motor word for every accepted light sample and compares the output words.
class steering_checker;
  longint center;
  longint kp;
  longint ki;
  longint kd;
  longint base_pwr;
  longint err_hist [DEPTH_DEFAULT];
  int hist_fill;
  int hist_pos;
  longint prev_err;
  motor_word_t pending_words [$];
  int checked;
  int failures;
  int saturated;

  function new();
    center = longint'(CENTER_RESET);
    kp = 0;
    ki = 0;
    kd = 0;
    base_pwr = 0;
    hist_fill = 0;
    hist_pos = 0;
    prev_err = 0;
    checked = 0;
    failures = 0;
    saturated = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_CENTER: center = longint'(data[LIGHT_W-1:0]);
      REG_GAIN_P: kp = longint'($signed(data));
      REG_GAIN_I: ki = longint'($signed(data));
      REG_GAIN_D: kd = longint'($signed(data));
      REG_BASE: base_pwr = longint'($signed(data[POWER_W-1:0]));
      default: ;
    endcase
  endfunction

  function void predict_steering(logic [LIGHT_W-1:0] level);
    longint err;
    longint sum;
    longint n;
    longint num;
    longint s;
    longint lp;
    longint rp;
    motor_word_t w;
    err = longint'(level) - center;
    err_hist[hist_pos] = err;
    hist_pos = (hist_pos + 1) % DEPTH_DEFAULT;
    if (hist_fill < DEPTH_DEFAULT) hist_fill++;
    // Only the entries written so far take part in the mean.
    sum = 0;
    for (int k = 0; k < hist_fill; k++) begin
      sum += err_hist[(hist_pos + DEPTH_DEFAULT - 1 - k) % DEPTH_DEFAULT];
    end
    n = longint'(hist_fill);
    num = kp * err * n + ki * sum + kd * (err - prev_err) * n;
    s = num / (256 * n);
    prev_err = err;
    if (s > 100) begin
      s = 100;
      saturated++;
    end else if (s < -100) begin
      s = -100;
      saturated++;
    end
    if (s > 0) begin
      lp = base_pwr;
      rp = (base_pwr * (100 - s)) / 100;
    end else begin
      lp = (base_pwr * (100 + s)) / 100;
      rp = base_pwr;
    end
    w.steer = s[POWER_W-1:0];
    w.left_power = lp[POWER_W-1:0];
    w.right_power = rp[POWER_W-1:0];
    pending_words.insert(pending_words.size(), w);
  endfunction

  function void check_word(motor_word_t got);
    motor_word_t want;
    if (pending_words.size() == 0) begin
      failures++;
      if (failures <= 10) begin
        $display("unexpected word: steer %0d left %0d right %0d",
                 got.steer, got.left_power, got.right_power);
      end
      return;
    end
    want = pending_words.pop_front();
    if (got.steer != want.steer || got.left_power != want.left_power ||
        got.right_power != want.right_power) begin
      failures++;
      if (failures <= 10) begin
        $display("word %0d: expected steer %0d left %0d right %0d, got %0d %0d %0d",
                 checked, want.steer, want.left_power, want.right_power,
                 got.steer, got.left_power, got.right_power);
      end
    end
    checked++;
  endfunction
endclass

module line_trace_pid_steering_unit_test;
  localparam int LIMIT_CYCLES = 1_200_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1650;
  localparam int NUM_REGS = int'(REG_BASE) + 1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_BASE + 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [LIGHT_W-1:0] light = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POWER_W-1:0] steer;
  logic signed [POWER_W-1:0] left_power;
  logic signed [POWER_W-1:0] right_power;

  steering_checker board;
  logic [CFG_DATA_W-1:0] plan [NUM_REGS];
  int samples_sent = 0;
  int settings = 0;
  int drain_pauses = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  logic [7:0] stall_tick = '0;

  line_trace_pid_steering_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .light(light),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .steer(steer),
    .left_power(left_power),
    .right_power(right_power)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver picks a new stall habit each time the 8-bit stall tick wraps to zero.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick == '0) stall_mode <= $urandom_range(0, 3);
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_tick[4];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_word(motor_word_t'({steer, left_power, right_power}));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout with %0d words outstanding", board.pending_words.size());
      $display("line_trace_pid_steering_unit verification failed");
      $finish;
    end
  end

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic apply_plan(input logic [NUM_REGS-1:0] which, input bit poke_unused);
    if (poke_unused) begin
      for (int u = int'(REG_FIRST_UNUSED); u < (1 << CFG_IDX_W); u++) begin
        write_one(CFG_IDX_W'(u), CFG_DATA_W'($urandom));
      end
    end
    for (int r = 0; r < NUM_REGS; r++) begin
      if (which[r]) write_one(CFG_IDX_W'(r), plan[r]);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic send_sample(input logic [LIGHT_W-1:0] level);
    in_valid <= 1'b1;
    light <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.predict_steering(level);
    samples_sent++;
  endtask

  // Gap must be at least one cycle so that valid is never lowered and raised
  // within the same step.
  task automatic pause_sender(input int gap);
    in_valid <= 1'b0;
    light <= LIGHT_W'($urandom);
    repeat (gap) @(posedge clk);
  endtask

  task automatic wait_empty();
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    pause_sender(1);
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LIGHT_W-1:0] pick_light();
    int v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: v = int'(board.center) + int'($urandom_range(0, 40)) - 20;
      10, 11, 12, 13, 14, 15, 16: v = $urandom_range(0, 100);
      default: v = $urandom_range(0, 127);
    endcase
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    return LIGHT_W'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    int g;
    case ($urandom_range(0, 7))
      0: g = 32767;
      1: g = -32768;
      2: g = 0;
      3, 4: g = int'($urandom_range(0, 1200)) - 600;
      5, 6: g = int'($urandom_range(0, 8192)) - 4096;
      default: g = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return CFG_DATA_W'(g);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_center();
    int c;
    case ($urandom_range(0, 7))
      0: c = 0;
      1: c = 127;
      2: c = $urandom_range(0, 127);
      default: c = $urandom_range(20, 80);
    endcase
    // Bits above the field are junk that the block must drop.
    return {9'($urandom), 7'(c)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_base();
    int b;
    case ($urandom_range(0, 9))
      0: b = -128;
      1: b = 127;
      2: b = 100;
      3: b = -100;
      4: b = 0;
      default: b = int'($urandom_range(0, 200)) - 100;
    endcase
    return {8'($urandom), 8'(b)};
  endfunction

  task automatic run_bursts(input int count);
    int remaining;
    int burst;
    remaining = count;
    while (remaining > 0) begin
      burst = $urandom_range(1, 8);
      if (burst > remaining) burst = remaining;
      repeat (burst) send_sample(pick_light());
      remaining -= burst;
      case ($urandom_range(0, 9))
        0: begin
          pause_sender(1);
          wait_empty();
          drain_pauses++;
        end
        1, 2: if (remaining == 0) pause_sender(1);
        default: pause_sender($urandom_range(1, 70));
      endcase
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Moderate gains while the window fills from one entry to five.
    plan[REG_CENTER] = 16'd50;
    plan[REG_GAIN_P] = 16'h0180;
    plan[REG_GAIN_I] = 16'h0040;
    plan[REG_GAIN_D] = 16'h0100;
    plan[REG_BASE] = 16'd80;
    apply_plan('1, 1'b1);
    send_sample(7'd0);
    send_sample(7'd127);
    send_sample(7'd50);
    send_sample(7'd100);
    send_sample(7'd60);
    send_sample(7'd40);
    send_sample(7'd50);
    settle();

    // Largest gains, lowest center, most negative base power.
    plan[REG_CENTER] = 16'hff80;
    plan[REG_GAIN_P] = 16'h7fff;
    plan[REG_GAIN_I] = 16'h8000;
    plan[REG_GAIN_D] = 16'h7fff;
    plan[REG_BASE] = 16'h5580;
    apply_plan('1, 1'b0);
    send_sample(7'd127);
    send_sample(7'd0);
    send_sample(7'd64);
    send_sample(7'd1);
    send_sample(7'd127);
    settle();

    plan[REG_CENTER] = 16'h007f;
    plan[REG_GAIN_P] = 16'h8000;
    plan[REG_GAIN_I] = 16'h7fff;
    plan[REG_GAIN_D] = 16'h8000;
    plan[REG_BASE] = 16'h007f;
    apply_plan('1, 1'b1);
    send_sample(7'd0);
    send_sample(7'd127);
    send_sample(7'd126);
    send_sample(7'd0);
    settle();

    // With all gains zero the steering is zero and the left motor gets base power.
    plan[REG_CENTER] = 16'd100;
    plan[REG_GAIN_P] = 16'h0000;
    plan[REG_GAIN_I] = 16'h0000;
    plan[REG_GAIN_D] = 16'h0000;
    plan[REG_BASE] = 16'hff9c;
    apply_plan('1, 1'b0);
    send_sample(7'd100);
    send_sample(7'd0);
    send_sample(7'd127);
    settle();

    // Unit proportional gain gives steering equal to the error, both signs.
    plan[REG_CENTER] = 16'd50;
    plan[REG_GAIN_P] = 16'h0100;
    plan[REG_BASE] = 16'd100;
    apply_plan('1, 1'b0);
    send_sample(7'd127);
    send_sample(7'd0);
    send_sample(7'd51);
    send_sample(7'd49);
    settle();

    while (samples_sent < RANDOM_ITEMS) begin
      plan[REG_CENTER] = pick_center();
      plan[REG_GAIN_P] = pick_gain();
      plan[REG_GAIN_I] = pick_gain();
      plan[REG_GAIN_D] = pick_gain();
      plan[REG_BASE] = pick_base();
      apply_plan(NUM_REGS'($urandom_range(1, (1 << NUM_REGS) - 1)),
                 $urandom_range(0, 7) == 0);
      run_bursts($urandom_range(30, 120));
      settle();
    end

    $display("covered %0d light samples under %0d register settings, %0d drain pauses",
             samples_sent, settings, drain_pauses);
    $display("compared %0d words, %0d with saturated steering, %0d mismatches",
             board.checked, board.saturated, board.failures);
    if (board.failures == 0 && board.pending_words.size() == 0) begin
      $display("line_trace_pid_steering_unit verification clean");
    end else begin
      $display("line_trace_pid_steering_unit verification failed");
    end
    $finish;
  end
endmodule
